// File: hdl/indexed_list_store_assert.svh
`ifndef INDEXED_LIST_STORE_ASSERT_SVH
`define INDEXED_LIST_STORE_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define ILS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that a condition in one cycle brings a consequence in the next.
`define ILS_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) cond |=> prop) else $error(msg);

`endif

// File: hdl/ils_pkg.sv
package ils_pkg;

    localparam int CNT_W  = 7;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 8;

    typedef enum logic [2:0] {
        ACT_INSERT = 3'd0,
        ACT_SET    = 3'd1,
        ACT_GET    = 3'd2,
        ACT_CLEAR  = 3'd3,
        ACT_MIN    = 3'd4,
        ACT_MAX    = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_CLAMP = 3'd2,
        ST_RANGE = 3'd3,
        ST_EMPTY = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_PLACE,
        S_GET,
        S_SCAN,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [CNT_W-1:0]         count;
        t_status                  status;
    } t_result;

endpackage

// File: hdl/indexed_list_store.sv
// Indexed list store: keeps an ordered list of signed 32-bit values in a single
// synchronous RAM of DEPTH words, with the count in a register. Items carry an
// action (insert, set, get, clear, minimum, maximum), an index and a value, and
// each item yields exactly one result with data, the count after the action and
// a status. One item is worked at a time; the time it takes is set by the one
// RAM read and one RAM write per cycle. Set, clear, refused items and an insert
// that appends go straight to the result; get reads one entry first; an insert
// at position p below the count n of entries first reads and writes back each
// entry at or above p one slot up, one per cycle, then writes the new value;
// minimum and maximum read the entries, one per cycle. A finished result sits
// in an output register, so the next item is taken while it waits. The limit on
// entries is the smaller of the capacity register and DEPTH; RAM contents are not
// cleared at reset, since only entries below the count are ever read.
module indexed_list_store
    import ils_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // index[7:0], value[39:8]
    input  logic [2:0]  i_s_axis_tuser,   // action[2:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // data[31:0], count[38:32], zero[39]
    output logic [2:0]  o_m_axis_tuser,   // status[2:0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CNT_W-1:0]  r_capacity;
    logic              r_ovalid;
    t_result           r_out;

    logic              res_valid;
    logic              res_ready;
    t_result           res;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic [AW-1:0]     raddr;
    logic [DATA_W-1:0] rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CNT_W'(64);
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_data;
        end
    end

    ils_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_action    (i_s_axis_tuser),
        .i_index     (i_s_axis_tdata[7:0]),
        .i_value     (i_s_axis_tdata[39:8]),
        .i_capacity  (r_capacity),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    ils_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // load the output register when it is empty or being drained
    assign res_ready = !r_ovalid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_ready) begin
            r_ovalid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {1'b0, r_out.count, r_out.data};
    assign o_m_axis_tuser  = r_out.status;

endmodule

// File: hdl/ils_ram.sv
module ils_ram
    import ils_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/ils_ctrl.sv
`include "indexed_list_store_assert.svh"

module ils_ctrl
    import ils_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [2:0]              i_action,
    input  logic signed [IDX_W-1:0] i_index,
    input  logic [DATA_W-1:0]       i_value,
    input  logic [CNT_W-1:0]        i_capacity,
    output logic                    o_res_valid,
    input  logic                    i_res_ready,
    output t_result                 o_res,
    output logic                    o_we,
    output logic [AW-1:0]           o_waddr,
    output logic [DATA_W-1:0]       o_wdata,
    output logic [AW-1:0]           o_raddr,
    input  logic [DATA_W-1:0]       i_rdata
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_j, n_j;
    logic [CNT_W-1:0]  r_pos, n_pos;
    logic [DATA_W-1:0] r_val, n_val;
    logic [DATA_W-1:0] r_data, n_data;
    t_status           r_status, n_status;
    logic              r_is_max, n_is_max;

    logic              accept;
    logic              negative;
    logic [CNT_W-1:0]  mag;
    logic              room;
    logic              in_range;
    logic              take;
    logic [CNT_W-1:0]  j_dec;

    assign accept   = (r_state == S_IDLE) && i_valid;
    assign negative = i_index[IDX_W-1];
    assign mag      = i_index[CNT_W-1:0];
    assign room     = (r_count < i_capacity) && (32'(r_count) < 32'(DEPTH));
    assign in_range = !negative && (mag < r_count);
    assign j_dec    = r_j - CNT_W'(1);
    assign take     = r_is_max ? ($signed(i_rdata) > $signed(r_data))
                               : ($signed(i_rdata) < $signed(r_data));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j      <= n_j;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_data   <= n_data;
        r_status <= n_status;
        r_is_max <= n_is_max;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_j      = r_j;
        n_pos    = r_pos;
        n_val    = r_val;
        n_data   = r_data;
        n_status = r_status;
        n_is_max = r_is_max;
        o_we     = 1'b0;
        o_waddr  = AW'(r_pos);
        o_wdata  = r_val;
        o_raddr  = AW'(r_j);
        o_res_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_data   = '0;
                    n_status = ST_OK;
                    n_state  = S_RESULT;
                    case (i_action)
                        ACT_INSERT: begin
                            if (!room) begin
                                n_status = ST_FULL;
                            end else begin
                                if (negative) begin
                                    n_pos    = '0;
                                    n_status = ST_CLAMP;
                                end else if (mag > r_count) begin
                                    n_pos    = r_count;
                                    n_status = ST_CLAMP;
                                end else begin
                                    n_pos = mag;
                                end
                                n_val = i_value;
                                if (n_pos == r_count) begin
                                    // append: no entries to move
                                    o_we    = 1'b1;
                                    o_waddr = AW'(r_count);
                                    o_wdata = i_value;
                                    n_count = r_count + CNT_W'(1);
                                end else begin
                                    o_raddr = AW'(r_count - CNT_W'(1));
                                    n_j     = r_count;
                                    n_state = S_SHIFT;
                                end
                            end
                        end
                        ACT_SET: begin
                            if (in_range) begin
                                o_we    = 1'b1;
                                o_waddr = AW'(mag);
                                o_wdata = i_value;
                            end else begin
                                n_status = ST_RANGE;
                            end
                        end
                        ACT_GET: begin
                            if (in_range) begin
                                o_raddr = AW'(mag);
                                n_state = S_GET;
                            end else begin
                                n_status = ST_RANGE;
                            end
                        end
                        ACT_CLEAR: begin
                            n_count = '0;
                        end
                        ACT_MIN, ACT_MAX: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                o_raddr  = '0;
                                n_j      = CNT_W'(1);
                                n_is_max = (i_action == ACT_MAX);
                                n_state  = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                // move the entry read last cycle up by one, fetch the one below
                o_we    = 1'b1;
                o_waddr = AW'(r_j);
                o_wdata = i_rdata;
                n_j     = j_dec;
                if (j_dec > r_pos) begin
                    o_raddr = AW'(j_dec - CNT_W'(1));
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                o_we    = 1'b1;
                o_waddr = AW'(r_pos);
                o_wdata = r_val;
                n_count = r_count + CNT_W'(1);
                n_state = S_RESULT;
            end
            S_GET: begin
                n_data  = i_rdata;
                n_state = S_RESULT;
            end
            S_SCAN: begin
                if ((r_j == CNT_W'(1)) || take) begin
                    n_data = i_rdata;
                end
                if (r_j < r_count) begin
                    o_raddr = AW'(r_j);
                    n_j     = r_j + CNT_W'(1);
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_res   = {r_data, r_count, r_status};

    `ILS_ASSERT(a_count_bound, (32'(r_count) <= 32'(DEPTH)), "entry count beyond depth")
    `ILS_ASSERT(a_shift_above_pos, ((r_state != S_SHIFT) || (r_j > r_pos)),
                "shift below insert position")
    `ILS_ASSERT(a_empty_zero, ((r_state != S_RESULT) || (r_status != ST_EMPTY) || (r_data == '0)),
                "empty result carries data")
    `ILS_ASSERT_NEXT(a_count_hold, (!accept && (r_state != S_PLACE)), $stable(r_count),
                     "entry count changed without an item")

endmodule
